// ===== hdl/hrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg
// shared types and constants of the http response deframer
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STATUS  = 4'd1,
    PH_HNAME   = 4'd2,
    PH_HVALUE  = 4'd3,
    PH_IDBODY  = 4'd4,
    PH_CSIZE   = 4'd5,
    PH_CDATA   = 4'd6,
    PH_CTRAIL1 = 4'd7,
    PH_CTRAIL2 = 4'd8
  } phase_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_X_LO  = 8'd120;
  localparam logic [7:0] CH_X_UP  = 8'd88;

  localparam logic [4:0] CL_LEN = 5'd14;
  localparam logic [4:0] TE_LEN = 5'd17;
  localparam logic [3:0] CK_LEN = 4'd7;
  localparam logic [3:0] VM_FAIL = 4'd15;

  // result word as handed to the output register
  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       complete;
    logic [9:0] status_code;
    logic       is_chunked;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] name_cl(input logic [4:0] i);
    case (i)
      5'd0: return "c";  5'd1: return "o";  5'd2: return "n";  5'd3: return "t";
      5'd4: return "e";  5'd5: return "n";  5'd6: return "t";  5'd7: return "-";
      5'd8: return "l";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "g";
      5'd12: return "t"; 5'd13: return "h";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_te(input logic [4:0] i);
    case (i)
      5'd0: return "t";  5'd1: return "r";  5'd2: return "a";  5'd3: return "n";
      5'd4: return "s";  5'd5: return "f";  5'd6: return "e";  5'd7: return "r";
      5'd8: return "-";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "c";
      5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
      5'd16: return "g";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] word_ck(input logic [3:0] i);
    case (i)
      4'd0: return "c"; 4'd1: return "h"; 4'd2: return "u"; 4'd3: return "n";
      4'd4: return "k"; 4'd5: return "e"; 4'd6: return "d";
      default: return 8'd0;
    endcase
  endfunction

endpackage

// ===== hdl/hrd_satacc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_satacc
// saturating acc * 10 + d or acc * 16 + d for length fields
// ----------------------------------------------------------------------------
module hrd_satacc #(
  parameter int LENGTH_BITS = hrd_pkg::LENGTH_BITS_DEF
) (
  input  logic [LENGTH_BITS-1:0] acc,
  input  logic                   hex,
  input  logic [3:0]             digit,
  output logic [LENGTH_BITS-1:0] result
);
  logic [LENGTH_BITS+4:0] wide;
  logic [LENGTH_BITS+4:0] lmax;

  always_comb begin
    lmax = {{5{1'b0}}, {LENGTH_BITS{1'b1}}};
    // shifts and adds only
    if (hex) begin
      wide = ({5'd0, acc} << 4) + {{(LENGTH_BITS+1){1'b0}}, digit};
    end else begin
      wide = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + {{(LENGTH_BITS+1){1'b0}}, digit};
    end
    result = (wide > lmax) ? {LENGTH_BITS{1'b1}} : wide[LENGTH_BITS-1:0];
  end
endmodule

// ===== hdl/http_response_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_deframer
// byte-wide http/1.1 response parser with identity and chunked body output
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with operation and data_byte; an input
//   word is taken when in_valid is high and in_stall is low
//   operation: start of response, data byte, connection closed
//   output channel: out_valid / out_stall, one result word per input word,
//   carrying body_valid, body_byte, complete, status_code and is_chunked
//   the result word enters the output register at the clock edge that accepts
//   the input word; throughput one word per cycle while not stalled, set by
//   the single parse update between the input acceptance and the result register
//   in_stall follows out_stall only when the output register holds a word
//   that is not taken, so a word can enter in the cycle the previous leaves
//   reset (rst, synchronous) sends the parser idle and empties the output
//   register; while the receiver stalls the result word holds still
// ----------------------------------------------------------------------------
module http_response_deframer #(
  parameter int LENGTH_BITS = hrd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       body_valid,
  output logic [7:0] body_byte,
  output logic       complete,
  output logic [9:0] status_code,
  output logic       is_chunked
);
  import hrd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};

  // parser state
  phase_t                 parse_phase, parse_phase_next;
  logic [9:0]             status_accum, status_accum_next;
  logic [1:0]             space_count, space_count_next;
  logic [1:0]             line_end_run, line_end_run_next;
  logic [4:0]             name_match_pos, name_match_pos_next;
  logic [1:0]             name_match_flags, name_match_flags_next;
  logic [3:0]             value_match_pos, value_match_pos_next;
  logic [LENGTH_BITS-1:0] content_length, content_length_next;
  logic                   chunked_mode, chunked_mode_next;
  logic [LENGTH_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic [LENGTH_BITS-1:0] body_count, body_count_next;

  result_t res_next, res;
  logic    take;

  logic [7:0] lc;
  logic       digit, hexd;
  logic [3:0] hexv;
  logic [LENGTH_BITS-1:0] cl_acc, cr_acc;
  logic [LENGTH_BITS-1:0] bc_inc;
  logic [13:0] st_wide;
  logic [1:0]  flg;
  logic        reported;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  assign lc    = to_lower(data_byte);
  assign digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);
  assign hexd  = digit || (lc >= 8'd97 && lc <= 8'd102);
  assign hexv  = digit ? data_byte[3:0] : 4'(lc - 8'd87);
  assign bc_inc = (body_count != LMAX) ? body_count + 1'b1 : body_count;
  assign st_wide = {4'd0, status_accum} * 14'd10 + {10'd0, data_byte[3:0]};

  hrd_satacc #(.LENGTH_BITS(LENGTH_BITS)) u_cl (
    .acc(content_length), .hex(1'b0), .digit(data_byte[3:0]), .result(cl_acc)
  );
  hrd_satacc #(.LENGTH_BITS(LENGTH_BITS)) u_cr (
    .acc(chunk_remaining), .hex(1'b1), .digit(hexv), .result(cr_acc)
  );

  always_comb begin
    parse_phase_next      = parse_phase;
    status_accum_next     = status_accum;
    space_count_next      = space_count;
    line_end_run_next     = line_end_run;
    name_match_pos_next   = name_match_pos;
    name_match_flags_next = name_match_flags;
    value_match_pos_next  = value_match_pos;
    content_length_next   = content_length;
    chunked_mode_next     = chunked_mode;
    chunk_remaining_next  = chunk_remaining;
    body_count_next       = body_count;
    res_next              = '0;
    flg                   = 2'd0;

    case (op_t'(operation))
      OP_START: begin
        status_accum_next = '0; space_count_next = '0; line_end_run_next = '0;
        name_match_pos_next = '0; name_match_flags_next = '0; value_match_pos_next = '0;
        content_length_next = '0; chunked_mode_next = 1'b0; chunk_remaining_next = '0;
        body_count_next = '0;
        parse_phase_next = PH_STATUS;
      end
      OP_CLOSE: begin
        if (parse_phase == PH_STATUS || parse_phase == PH_HNAME ||
            parse_phase == PH_HVALUE) begin
          status_accum_next = '0;
          chunked_mode_next = 1'b0;
          parse_phase_next = PH_IDLE;
          res_next.complete = 1'b1;
        end else if (parse_phase != PH_IDLE) begin
          parse_phase_next = PH_IDLE;
          res_next.complete = 1'b1;
        end
      end
      OP_DATA: begin
        case (parse_phase)
          PH_STATUS: begin
            if (data_byte == CH_LF && line_end_run == 2'd1) begin
              parse_phase_next = PH_HNAME; name_match_pos_next = '0;
              name_match_flags_next = 2'd3; value_match_pos_next = '0;
              line_end_run_next = 2'd2;
            end else begin
              line_end_run_next = (data_byte == CH_CR) ? 2'd1 : 2'd0;
              if (space_count == 2'd0) begin
                if (data_byte == CH_SP) space_count_next = 2'd1;
              end else if (space_count == 2'd1) begin
                if (digit) begin
                  status_accum_next = (st_wide > 14'd999) ? 10'd999 : st_wide[9:0];
                end else begin
                  space_count_next = 2'd2;
                end
              end
            end
          end
          PH_HNAME, PH_HVALUE: begin
            if (data_byte == CH_LF && line_end_run == 2'd3) begin
              if (chunked_mode) begin
                parse_phase_next = PH_CSIZE; value_match_pos_next = '0;
                line_end_run_next = '0; chunk_remaining_next = '0;
              end else if (content_length == '0) begin
                parse_phase_next = PH_IDLE; res_next.complete = 1'b1;
              end else begin
                parse_phase_next = PH_IDBODY;
              end
            end else if (data_byte == CH_LF && line_end_run == 2'd1) begin
              if (parse_phase == PH_HVALUE && name_match_flags == 2'd2 &&
                  value_match_pos == CK_LEN)
                chunked_mode_next = 1'b1;
              parse_phase_next = PH_HNAME; name_match_pos_next = '0;
              name_match_flags_next = 2'd3; value_match_pos_next = '0;
              line_end_run_next = 2'd2;
            end else begin
              line_end_run_next = (data_byte == CH_CR) ?
                                  ((line_end_run == 2'd2) ? 2'd3 : 2'd1) : 2'd0;
              if (parse_phase == PH_HNAME) begin
                if (data_byte == CH_COLON) begin
                  flg[0] = name_match_flags[0] && name_match_pos == CL_LEN;
                  flg[1] = name_match_flags[1] && name_match_pos == TE_LEN;
                  name_match_flags_next = flg;
                  value_match_pos_next = '0;
                  if (flg[0]) content_length_next = '0;
                  parse_phase_next = PH_HVALUE;
                end else begin
                  flg = name_match_flags;
                  if (name_match_pos >= CL_LEN || name_cl(name_match_pos) != lc) flg[0] = 1'b0;
                  if (name_match_pos >= TE_LEN || name_te(name_match_pos) != lc) flg[1] = 1'b0;
                  name_match_flags_next = flg;
                  if (name_match_pos != 5'd31) name_match_pos_next = name_match_pos + 5'd1;
                end
              end else if (name_match_flags[0]) begin
                if (value_match_pos == 4'd0 && is_ws(data_byte)) begin
                  value_match_pos_next = value_match_pos;
                end else if (value_match_pos <= 4'd1 && digit) begin
                  value_match_pos_next = 4'd1;
                  content_length_next = cl_acc;
                end else begin
                  value_match_pos_next = VM_FAIL;
                end
              end else if (name_match_flags[1]) begin
                if (value_match_pos == VM_FAIL) begin
                  value_match_pos_next = VM_FAIL;
                end else if (value_match_pos == CK_LEN) begin
                  if (!is_ws(data_byte)) value_match_pos_next = VM_FAIL;
                end else if (value_match_pos == 4'd0 && is_ws(data_byte)) begin
                  value_match_pos_next = value_match_pos;
                end else if (word_ck(value_match_pos) == lc) begin
                  value_match_pos_next = value_match_pos + 4'd1;
                end else begin
                  value_match_pos_next = VM_FAIL;
                end
              end
            end
          end
          PH_IDBODY: begin
            res_next.body_valid = 1'b1; res_next.body_byte = data_byte;
            body_count_next = bc_inc;
            if (bc_inc >= content_length) begin
              parse_phase_next = PH_IDLE; res_next.complete = 1'b1;
            end
          end
          PH_CSIZE: begin
            if (data_byte == CH_LF && line_end_run == 2'd1) begin
              line_end_run_next = '0;
              if (chunk_remaining == '0) begin
                parse_phase_next = PH_IDLE; res_next.complete = 1'b1;
              end else begin
                parse_phase_next = PH_CDATA;
              end
            end else begin
              line_end_run_next = (data_byte == CH_CR) ? 2'd1 : 2'd0;
              if (value_match_pos == 4'd0 && is_ws(data_byte)) begin
                value_match_pos_next = value_match_pos;
              end else if (value_match_pos == 4'd0 && data_byte == CH_ZERO) begin
                value_match_pos_next = 4'd2;
              end else if (value_match_pos == 4'd2 &&
                           (data_byte == CH_X_LO || data_byte == CH_X_UP)) begin
                value_match_pos_next = 4'd1;
              end else if (value_match_pos <= 4'd2 && hexd) begin
                value_match_pos_next = 4'd1;
                chunk_remaining_next = cr_acc;
              end else begin
                value_match_pos_next = VM_FAIL;
              end
            end
          end
          PH_CDATA: begin
            res_next.body_valid = 1'b1; res_next.body_byte = data_byte;
            body_count_next = bc_inc;
            chunk_remaining_next = chunk_remaining - 1'b1;
            if (chunk_remaining == {{(LENGTH_BITS-1){1'b0}}, 1'b1})
              parse_phase_next = PH_CTRAIL1;
          end
          PH_CTRAIL1: parse_phase_next = PH_CTRAIL2;
          PH_CTRAIL2: begin
            parse_phase_next = PH_CSIZE; value_match_pos_next = '0;
            line_end_run_next = '0; chunk_remaining_next = '0;
          end
          default: parse_phase_next = parse_phase;
        endcase
      end
      default: parse_phase_next = parse_phase;
    endcase

    // status fields show only outside the status line and the header section
    reported = (parse_phase_next == PH_IDLE) || (parse_phase_next >= PH_IDBODY);
    res_next.status_code = reported ? status_accum_next : 10'd0;
    res_next.is_chunked  = reported ? chunked_mode_next : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_IDLE;
      status_accum <= '0; space_count <= '0; line_end_run <= '0;
      name_match_pos <= '0; name_match_flags <= '0; value_match_pos <= '0;
      content_length <= '0; chunked_mode <= 1'b0; chunk_remaining <= '0;
      body_count <= '0;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      status_accum <= status_accum_next; space_count <= space_count_next;
      line_end_run <= line_end_run_next; name_match_pos <= name_match_pos_next;
      name_match_flags <= name_match_flags_next;
      value_match_pos <= value_match_pos_next;
      content_length <= content_length_next; chunked_mode <= chunked_mode_next;
      chunk_remaining <= chunk_remaining_next; body_count <= body_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign body_valid  = res.body_valid;
  assign body_byte   = res.body_byte;
  assign complete    = res.complete;
  assign status_code = res.status_code;
  assign is_chunked  = res.is_chunked;

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted word did not reach output");
  a_idle_no_body: assert property (@(posedge clk) disable iff (rst)
    (take && parse_phase == PH_IDLE && operation != OP_START) |=> !body_valid)
    else $error("body byte while idle");
  a_complete_idle: assert property (@(posedge clk) disable iff (rst)
    (take && res_next.complete) |=> parse_phase == PH_IDLE)
    else $error("complete without going idle");
endmodule
